>>> design/esn_pkg.sv
package esn_pkg;

	localparam int MAX_ROW_DEF     = 1024;
	localparam int SAMPLE_BITS_DEF = 17;

	localparam int TW_W        = 10;
	localparam int TH_W        = 13;
	localparam int TH_MAX      = 4096;
	localparam int NULL_W      = 17;
	localparam int GAIN_W      = 48;
	localparam int GAIN_HALF   = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int OUT_W       = 16;
	localparam int NORM_W      = 31;
	localparam int Z_SHIFT     = 25;
	localparam int SUM_W       = 64;
	localparam int ROOT_W      = 32;
	localparam int FRAC_BITS   = 16;
	localparam int STEP_W      = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH  = 3'd0,
		REG_TILE_HEIGHT = 3'd1,
		REG_NULL_VALUE  = 3'd2,
		REG_X_GAIN      = 3'd3,
		REG_Y_GAIN      = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		FE_IDLE,
		FE_WRITE
	} fe_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_MUL,
		C_NORM,
		C_SQ,
		C_SQRT,
		C_DIV,
		C_DONE
	} calc_state_t;

	typedef struct packed {
		logic start;
		logic last;
	} win_ctl_t;

endpackage

>>> design/esn_line_store.sv
module esn_line_store #(
	parameter int MAX_ROW     = esn_pkg::MAX_ROW_DEF,
	parameter int SAMPLE_BITS = esn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] height,
	input  logic [esn_pkg::TW_W-1:0]      tile_width,
	input  logic [esn_pkg::TH_W-1:0]      tile_height,
	output logic                          idle,
	output esn_pkg::win_ctl_t             win_ctl,
	output logic signed [SAMPLE_BITS-1:0] c,
	output logic signed [SAMPLE_BITS-1:0] x_lo,
	output logic signed [SAMPLE_BITS-1:0] x_hi,
	output logic signed [SAMPLE_BITS-1:0] y_lo,
	output logic signed [SAMPLE_BITS-1:0] y_hi
);
	import esn_pkg::*;

	localparam int CW = $clog2(MAX_ROW);
	localparam int WW = (CW + 1 > TW_W) ? CW + 1 : TW_W;
	localparam logic [WW-1:0] TW_MAX = WW'(MAX_ROW - 2);

	fe_state_t state_q, state_d;
	logic [CW-1:0]   col_q;
	logic [TH_W-1:0] row_q;
	logic signed [SAMPLE_BITS-1:0] cur_s1, up_rd_s1, mid_rd_s1;
	logic signed [SAMPLE_BITS-1:0] w0_q, w1_q, w2_q, w3_q;
	logic signed [SAMPLE_BITS-1:0] upper_mem  [MAX_ROW];
	logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_ROW];

	logic [WW-1:0]   tw_eff, wi, col_ext, col_inc;
	logic [TH_W-1:0] th_eff, hi, row_inc;
	logic            wrap_col, wrap_row;

	always_comb begin
		tw_eff = WW'(tile_width);
		if (tw_eff == '0) begin
			tw_eff = WW'(1);
		end else if (tw_eff > TW_MAX) begin
			tw_eff = TW_MAX;
		end
		th_eff = tile_height;
		if (th_eff == '0) begin
			th_eff = TH_W'(1);
		end else if (th_eff > TH_W'(TH_MAX)) begin
			th_eff = TH_W'(TH_MAX);
		end
		wi       = tw_eff + WW'(2);
		hi       = th_eff + TH_W'(2);
		col_ext  = WW'(col_q);
		col_inc  = col_ext + WW'(1);
		row_inc  = row_q + TH_W'(1);
		wrap_col = col_inc >= wi;
		wrap_row = row_inc >= hi;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE:  if (accept) state_d = FE_WRITE;
			FE_WRITE: state_d = FE_IDLE;
			default:  state_d = FE_IDLE;
		endcase
	end

	assign idle          = (state_q == FE_IDLE);
	assign win_ctl.start = (state_q == FE_WRITE) && (col_ext >= WW'(2)) && (row_q >= TH_W'(2));
	assign win_ctl.last  = (row_q >= hi - TH_W'(1)) && (col_ext >= wi - WW'(1));
	assign c    = w0_q;
	assign x_lo = w1_q;
	assign x_hi = mid_rd_s1;
	assign y_lo = w2_q;
	assign y_hi = w3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			w0_q    <= '0;
			w1_q    <= '0;
			w2_q    <= '0;
			w3_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FE_WRITE) begin
				w1_q <= w0_q;
				w0_q <= mid_rd_s1;
				w2_q <= up_rd_s1;
				w3_q <= cur_s1;
				if (wrap_col) begin
					col_q <= '0;
					row_q <= wrap_row ? '0 : row_inc;
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
		end
	end

	// read registered at accept, write-back in the next cycle; ready stays low meanwhile
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1  <= upper_mem[col_q];
			mid_rd_s1 <= middle_mem[col_q];
			cur_s1    <= height;
		end
		if (state_q == FE_WRITE) begin
			upper_mem[col_q]  <= mid_rd_s1;
			middle_mem[col_q] <= cur_s1;
		end
	end

endmodule

>>> design/esn_normal_calc.sv
module esn_normal_calc #(
	parameter int SAMPLE_BITS = esn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  esn_pkg::win_ctl_t                win_ctl,
	input  logic signed [SAMPLE_BITS-1:0]    c,
	input  logic signed [SAMPLE_BITS-1:0]    x_lo,
	input  logic signed [SAMPLE_BITS-1:0]    x_hi,
	input  logic signed [SAMPLE_BITS-1:0]    y_lo,
	input  logic signed [SAMPLE_BITS-1:0]    y_hi,
	input  logic signed [esn_pkg::NULL_W-1:0] null_value,
	input  logic [esn_pkg::GAIN_W-1:0]       x_gain,
	input  logic [esn_pkg::GAIN_W-1:0]       y_gain,
	input  logic                             take,
	output logic                             idle,
	output logic                             res_valid,
	output logic signed [esn_pkg::OUT_W-1:0] res_x,
	output logic signed [esn_pkg::OUT_W-1:0] res_y,
	output logic [esn_pkg::OUT_W-1:0]        res_z,
	output logic                             res_last
);
	import esn_pkg::*;

	localparam int DW   = SAMPLE_BITS + 1;
	localparam int MAGW = SAMPLE_BITS + 2;
	localparam int PW   = GAIN_HALF + MAGW;
	localparam int MW   = GAIN_W + MAGW;
	localparam int CMPW = 33;
	// m * 2^16 + r can carry into one bit above m's 31 + 16
	localparam int NUMW = NORM_W + FRAC_BITS + 1;
	localparam int DVW  = ROOT_W + 1;
	localparam logic [OUT_W-1:0] SAT_POS = 16'd32767;

	// {neg, magnitude}; one-sided differences count double
	function automatic logic [MAGW:0] grad(
		input logic signed [SAMPLE_BITS-1:0] lo_s,
		input logic signed [SAMPLE_BITS-1:0] ce,
		input logic signed [SAMPLE_BITS-1:0] hi_s,
		input logic signed [NULL_W-1:0]      nul
	);
		logic signed [CMPW-1:0] l, m, h, n;
		logic signed [DW-1:0]   d;
		logic [DW-1:0]          a;
		logic                   dbl;
		logic [MAGW-1:0]        mag;
		l   = CMPW'(lo_s);
		m   = CMPW'(ce);
		h   = CMPW'(hi_s);
		n   = CMPW'(nul);
		d   = '0;
		dbl = 1'b0;
		if (h != n) begin
			if (l != n) begin
				d = DW'(hi_s) - DW'(lo_s);
			end else if (m != n) begin
				d   = DW'(hi_s) - DW'(ce);
				dbl = 1'b1;
			end
		end else if (m != n && l != n) begin
			d   = DW'(ce) - DW'(lo_s);
			dbl = 1'b1;
		end
		a   = (d < 0) ? DW'(-d) : DW'(d);
		mag = dbl ? {a, 1'b0} : {1'b0, a};
		return {(d < 0), mag};
	endfunction

	calc_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        comp_q;
	logic [MAGW-1:0]   mag_x_q, mag_y_q;
	logic              neg_x_q, neg_y_q, last_q;
	logic [MW-1:0]     mx_q, my_q;
	logic [Z_SHIFT:0]  az_q;
	logic [SUM_W-1:0]  s_q, r_q, bit_q;
	logic [DVW-1:0]    rem_q;
	logic [FRAC_BITS-1:0] lo_q, q_q;
	logic [OUT_W-1:0]  qx_q, qy_q, qz_q;

	logic [MAGW:0]        gx, gy;
	logic [GAIN_HALF-1:0] half;
	logic [MAGW-1:0]      mag_sel;
	logic [PW-1:0]        prod;
	logic [MW-1:0]        addend, acc_new;
	logic                 big;
	logic [NORM_W-1:0]    op;
	logic [2*NORM_W-1:0]  sq;
	logic [SUM_W-1:0]     trial;
	logic                 root_ge;
	logic [ROOT_W-1:0]    root;
	logic [DVW-1:0]       dvs;
	logic [NUMW-1:0]      num;
	logic [DVW:0]         rem2;
	logic                 div_ge;
	logic [FRAC_BITS-1:0] q_next;
	logic [OUT_W-1:0]     sx, sy;

	always_comb begin
		gx = grad(x_lo, c, x_hi, null_value);
		gy = grad(y_lo, c, y_hi, null_value);

		half    = step_q[0] ? (step_q[1] ? y_gain[GAIN_W-1:GAIN_HALF] : x_gain[GAIN_W-1:GAIN_HALF])
		                    : (step_q[1] ? y_gain[GAIN_HALF-1:0] : x_gain[GAIN_HALF-1:0]);
		mag_sel = step_q[1] ? mag_y_q : mag_x_q;
		prod    = PW'(half) * PW'(mag_sel);
		addend  = step_q[0] ? (MW'(prod) << GAIN_HALF) : MW'(prod);
		acc_new = step_q[0] ? ((step_q[1] ? my_q : mx_q) + addend) : addend;

		big = (|mx_q[MW-1:NORM_W]) || (|my_q[MW-1:NORM_W]);

		case (step_q[1:0])
			2'd0:    op = mx_q[NORM_W-1:0];
			2'd1:    op = my_q[NORM_W-1:0];
			default: op = NORM_W'(az_q);
		endcase
		sq = (2*NORM_W)'(op) * (2*NORM_W)'(op);

		trial   = r_q + bit_q;
		root_ge = s_q >= trial;

		root = (r_q[ROOT_W-1:0] == '0) ? ROOT_W'(1) : r_q[ROOT_W-1:0];
		dvs  = {root, 1'b0};
		case (comp_q)
			2'd0:    num = NUMW'({mx_q[NORM_W-1:0], {FRAC_BITS{1'b0}}}) + NUMW'(root);
			2'd1:    num = NUMW'({my_q[NORM_W-1:0], {FRAC_BITS{1'b0}}}) + NUMW'(root);
			default: num = NUMW'({NORM_W'(az_q), {FRAC_BITS{1'b0}}}) + NUMW'(root);
		endcase
		rem2   = {rem_q, lo_q[FRAC_BITS-1]};
		div_ge = rem2 >= {1'b0, dvs};
		q_next = {q_q[FRAC_BITS-2:0], div_ge};

		sx = (qx_q > SAT_POS) ? SAT_POS : qx_q;
		sy = (qy_q > SAT_POS) ? SAT_POS : qy_q;
	end

	assign res_x     = neg_x_q ? -$signed(sx) : $signed(sx);
	assign res_y     = neg_y_q ? -$signed(sy) : $signed(sy);
	assign res_z     = qz_q;
	assign res_last  = last_q;
	assign res_valid = (state_q == C_DONE);
	assign idle      = (state_q == C_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (win_ctl.start) state_d = C_MUL;
			C_MUL:  if (step_q[1:0] == 2'd3) state_d = C_NORM;
			C_NORM: if (!big) state_d = C_SQ;
			C_SQ:   if (step_q[1:0] == 2'd2) state_d = C_SQRT;
			C_SQRT: if (bit_q[0]) state_d = C_DIV;
			C_DIV:  if (step_q == STEP_W'(FRAC_BITS) && comp_q == 2'd2) state_d = C_DONE;
			C_DONE: if (take) state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				step_q <= '0;
				comp_q <= '0;
			end else if (state_q == C_DIV && step_q == STEP_W'(FRAC_BITS)) begin
				step_q <= '0;
				comp_q <= comp_q + 2'd1;
			end else if (state_q == C_MUL || state_q == C_SQ || state_q == C_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (win_ctl.start) begin
					neg_x_q <= gx[MAGW];
					mag_x_q <= gx[MAGW-1:0];
					neg_y_q <= gy[MAGW];
					mag_y_q <= gy[MAGW-1:0];
					last_q  <= win_ctl.last;
					az_q    <= (Z_SHIFT+1)'(1) << Z_SHIFT;
				end
			end
			C_MUL: begin
				if (step_q[1]) my_q <= acc_new;
				else           mx_q <= acc_new;
			end
			C_NORM: begin
				s_q <= '0;
				if (big) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
					az_q <= az_q >> 1;
				end
			end
			C_SQ: begin
				s_q   <= s_q + SUM_W'(sq);
				r_q   <= '0;
				bit_q <= SUM_W'(1) << (SUM_W - 2);
			end
			C_SQRT: begin
				if (root_ge) begin
					s_q <= s_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			C_DIV: begin
				if (step_q == '0) begin
					rem_q <= DVW'(num >> FRAC_BITS);
					lo_q  <= num[FRAC_BITS-1:0];
					q_q   <= '0;
				end else begin
					rem_q <= div_ge ? DVW'(rem2 - {1'b0, dvs}) : rem2[DVW-1:0];
					lo_q  <= lo_q << 1;
					q_q   <= q_next;
					if (step_q == STEP_W'(FRAC_BITS)) begin
						case (comp_q)
							2'd0:    qx_q <= q_next;
							2'd1:    qy_q <= q_next;
							default: qz_q <= q_next;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

endmodule

>>> design/elevation_surface_normal_core.sv
// Channel  | Direction | Handshake             | Word
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// in       | in        | in_valid / in_ready   | height
// out      | out       | out_valid / out_ready | normal_x, normal_y, normal_z, last_of_tile
//
// Border samples only go through a line-store read, then a write-back.
// Interior pixels go through the read, write-back, 4 gain-multiply steps, 1 + s normalize steps
// (s = 0..35 shifts), 3 squares, 32 root steps, 3 x 17 divide steps and a handoff.
// Reset is asynchronous, active low; line stores are not cleared.
// A finished word waits in the output register; a new sample is taken meanwhile.
// cfg_ready is always high; registers are to be written only while the block is idle (the block does not check).
module elevation_surface_normal_core #(
	parameter int MAX_ROW     = esn_pkg::MAX_ROW_DEF,
	parameter int SAMPLE_BITS = esn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [esn_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [esn_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        height,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [esn_pkg::OUT_W-1:0]     normal_x,
	output logic signed [esn_pkg::OUT_W-1:0]     normal_y,
	output logic [esn_pkg::OUT_W-1:0]            normal_z,
	output logic                                 last_of_tile
);
	import esn_pkg::*;

	// configuration registers
	logic [TW_W-1:0]          tile_width_q;
	logic [TH_W-1:0]          tile_height_q;
	logic signed [NULL_W-1:0] null_value_q;
	logic [GAIN_W-1:0]        x_gain_q, y_gain_q;

	logic ls_idle, calc_idle, accept;
	win_ctl_t win_ctl;
	logic signed [SAMPLE_BITS-1:0] c, x_lo, x_hi, y_lo, y_hi;

	logic res_valid, res_last, load;
	logic signed [OUT_W-1:0] res_x, res_y;
	logic [OUT_W-1:0]        res_z;

	logic                    out_valid_q, last_q;
	logic signed [OUT_W-1:0] nx_q, ny_q;
	logic [OUT_W-1:0]        nz_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= TW_W'(64);
			tile_height_q <= TH_W'(64);
			null_value_q  <= '0;
			x_gain_q      <= GAIN_W'(1) << GAIN_HALF;
			y_gain_q      <= GAIN_W'(1) << GAIN_HALF;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TILE_WIDTH:  tile_width_q  <= cfg_data[TW_W-1:0];
				REG_TILE_HEIGHT: tile_height_q <= cfg_data[TH_W-1:0];
				REG_NULL_VALUE:  null_value_q  <= cfg_data[NULL_W-1:0];
				REG_X_GAIN:      x_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_Y_GAIN:      y_gain_q      <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// one sample in flight at a time
	assign in_ready = ls_idle && calc_idle;
	assign accept   = in_valid && in_ready;

	esn_line_store #(
		.MAX_ROW    (MAX_ROW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_line_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.height     (height),
		.tile_width (tile_width_q),
		.tile_height(tile_height_q),
		.idle       (ls_idle),
		.win_ctl    (win_ctl),
		.c          (c),
		.x_lo       (x_lo),
		.x_hi       (x_hi),
		.y_lo       (y_lo),
		.y_hi       (y_hi)
	);

	esn_normal_calc #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_ctl   (win_ctl),
		.c         (c),
		.x_lo      (x_lo),
		.x_hi      (x_hi),
		.y_lo      (y_lo),
		.y_hi      (y_hi),
		.null_value(null_value_q),
		.x_gain    (x_gain_q),
		.y_gain    (y_gain_q),
		.take      (load),
		.idle      (calc_idle),
		.res_valid (res_valid),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_z     (res_z),
		.res_last  (res_last)
	);

	// output register: loads when empty or draining this cycle
	assign load = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nx_q   <= res_x;
			ny_q   <= res_y;
			nz_q   <= res_z;
			last_q <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign normal_x     = nx_q;
	assign normal_y     = ny_q;
	assign normal_z     = nz_q;
	assign last_of_tile = last_q;

endmodule

>>> design/esn_checker.sv
module esn_checker #(
	parameter int SAMPLE_BITS = esn_pkg::SAMPLE_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic signed [SAMPLE_BITS-1:0]    height,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [esn_pkg::OUT_W-1:0] normal_x,
	input logic signed [esn_pkg::OUT_W-1:0] normal_y,
	input logic [esn_pkg::OUT_W-1:0]        normal_z
);
	import esn_pkg::*;

	// a pending input word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(height))
		else $error("input word dropped while stalled");

	// one sample in flight: ready drops after each accept
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken during line-store write-back");

	// a stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(normal_x) &&
			$stable(normal_y) && $stable(normal_z))
		else $error("output word changed while stalled");

	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_z <= 16'd32768)
		else $error("normal_z above one");

	a_xy_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x != 16'sh8000 && normal_y != 16'sh8000)
		else $error("x or y component not saturated to 32767");

endmodule

bind elevation_surface_normal_core esn_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_esn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.height   (height),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.normal_x (normal_x),
	.normal_y (normal_y),
	.normal_z (normal_z)
);

>>> verif/elevation_surface_normal_core_test.sv
module elevation_surface_normal_core_test;
	import esn_pkg::*;

	// One result word: the unit normal of an interior pixel.
	typedef struct {
		logic signed [OUT_W-1:0] nx;
		logic signed [OUT_W-1:0] ny;
		logic [OUT_W-1:0]        nz;
		logic                    last;
	} normal_t;

	// Directed 1x1 tiles: 3x3 padded samples in raster order, one result each.
	// chk marks rows whose normal is typed in; the others go through the predictor.
	typedef struct {
		logic [TW_W-1:0]          w;
		logic [TH_W-1:0]          h;
		logic signed [NULL_W-1:0] nul;
		logic [GAIN_W-1:0]        xg;
		logic [GAIN_W-1:0]        yg;
		logic signed [16:0]       px [9];
		bit                       chk;
		normal_t                  want;
	} tile_row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_WAIT     = 300;
	localparam int RANDOM_ITEMS   = 700;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 48'd16777216;
	localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_BITS_DEF-1:0] height = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] normal_x;
	logic signed [OUT_W-1:0] normal_y;
	logic [OUT_W-1:0] normal_z;
	logic last_of_tile;

	always #2 clk = ~clk;

	elevation_surface_normal_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .height(height),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.last_of_tile(last_of_tile)
	);

	// Shadow copy of the block: registers, line stores, window and counts.
	logic [TW_W-1:0]          width_reg;
	logic [TH_W-1:0]          height_reg;
	logic signed [NULL_W-1:0] null_reg;
	logic [GAIN_W-1:0]        xgain_reg;
	logic [GAIN_W-1:0]        ygain_reg;
	logic signed [16:0] upper_line [MAX_ROW_DEF];
	logic signed [16:0] middle_line [MAX_ROW_DEF];
	logic signed [16:0] win [4];
	int col_pos, row_pos;

	normal_t pending_normals[$];
	int      mismatches = 0;
	int      send_pct = 0, recv_pct = 0;
	int      hold_asks = 0, hold_done = 0, hold_left = 0;
	int      idle_cycles = 0;
	int      items_sent = 0;

	// Gradient magnitude along one axis, units of 2^-25.
	function automatic logic [95:0] axis_slope(longint lo_s, longint c, longint hi_s,
		longint nul, logic [GAIN_W-1:0] g, output bit neg);
		longint d;
		longint mult;
		logic [95:0] a;
		d = 0;
		mult = 0;
		neg = 1'b0;
		if (hi_s != nul) begin
			if (lo_s != nul) begin
				d = hi_s - lo_s;
				mult = 1;
			end else if (c != nul) begin
				d = hi_s - c;
				mult = 2;
			end
		end else if (c != nul && lo_s != nul) begin
			d = c - lo_s;
			mult = 2;
		end
		if (mult == 0 || d == 0)
			return '0;
		neg = d < 0;
		a = 96'((d < 0 ? -d : d) * mult);
		return a * {48'b0, g};
	endfunction

	function automatic int bit_length(logic [95:0] v);
		for (int i = 95; i >= 0; i--)
			if (v[i])
				return i + 1;
		return 0;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] unit_part(logic [63:0] m, logic [63:0] r);
		return (m * 64'd65536 + r) / (64'd2 * r);
	endfunction

	function automatic logic signed [OUT_W-1:0] clip_signed(logic [63:0] mag, bit neg);
		if (mag > 64'd32767)
			mag = 64'd32767;
		return neg ? -$signed(mag[15:0]) : $signed(mag[15:0]);
	endfunction

	// Advance the shadow by one sample; returns 1 when a normal comes out.
	function automatic bit normal_of_sample(logic signed [16:0] h, output normal_t res);
		int tw, th, wi, hi, idx, sh, l;
		logic signed [16:0] up_c, mid_c;
		logic [95:0] mx, my, mz;
		logic [63:0] ax, ay, az, r, zc;
		bit nxn, nyn, made;
		tw = width_reg;
		th = height_reg;
		if (tw < 1) tw = 1;
		if (tw > MAX_ROW_DEF - 2) tw = MAX_ROW_DEF - 2;
		if (th < 1) th = 1;
		if (th > TH_MAX) th = TH_MAX;
		wi = tw + 2;
		hi = th + 2;
		idx = col_pos < MAX_ROW_DEF ? col_pos : MAX_ROW_DEF - 1;
		up_c = upper_line[idx];
		mid_c = middle_line[idx];
		made = 1'b0;
		res = '{default: '0};
		if (col_pos >= 2 && row_pos >= 2) begin
			mx = axis_slope(win[1], win[0], mid_c, null_reg, xgain_reg, nxn);
			my = axis_slope(win[2], win[0], win[3], null_reg, ygain_reg, nyn);
			mz = 96'd1 << Z_SHIFT;
			l = bit_length(mx);
			if (bit_length(my) > l) l = bit_length(my);
			if (bit_length(mz) > l) l = bit_length(mz);
			sh = l > 31 ? l - 31 : 0;
			ax = 64'(mx >> sh);
			ay = 64'(my >> sh);
			az = 64'(mz >> sh);
			r = int_sqrt(ax * ax + ay * ay + az * az);
			if (r == 0) r = 1;
			res.nx = clip_signed(unit_part(ax, r), nxn);
			res.ny = clip_signed(unit_part(ay, r), nyn);
			zc = unit_part(az, r);
			res.nz = zc > 64'd32768 ? 16'd32768 : zc[15:0];
			res.last = (row_pos >= hi - 1 && col_pos >= wi - 1);
			made = 1'b1;
		end
		win[1] = win[0];
		win[0] = mid_c;
		win[2] = up_c;
		win[3] = h;
		upper_line[idx] = mid_c;
		middle_line[idx] = h;
		if (col_pos + 1 >= wi) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= hi) ? 0 : row_pos + 1;
		end else
			col_pos = col_pos + 1;
		return made;
	endfunction

	// Effective tile geometry after saturation.
	function automatic int eff_width();
		return width_reg < 1 ? 1 : (width_reg > MAX_ROW_DEF - 2 ? MAX_ROW_DEF - 2 : width_reg);
	endfunction

	function automatic int eff_height();
		return height_reg < 1 ? 1 : (height_reg > TH_MAX ? TH_MAX : height_reg);
	endfunction

	// Register write; caller makes sure the block is idle.
	// Waits for the next falling edge after cfg_valid drops, so back-to-back calls never
	// touch cfg_valid twice in one time step.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_TILE_WIDTH:  width_reg = data[TW_W-1:0];
			REG_TILE_HEIGHT: height_reg = data[TH_W-1:0];
			REG_NULL_VALUE:  null_reg = data[NULL_W-1:0];
			REG_X_GAIN:      xgain_reg = data[GAIN_W-1:0];
			REG_Y_GAIN:      ygain_reg = data[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one sample; on acceptance queue its normal, typed or predicted.
	task automatic push_height(logic signed [16:0] h, bit typed, normal_t want);
		normal_t got;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		height <= h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (normal_of_sample(h, got)) begin
			if (typed)
				got = want;
			pending_normals = {pending_normals, got};
		end
		@(negedge clk);
	endtask

	// Wait for the block to go idle: all normals back, trailing border samples done.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_normals.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		int k;
		k = $urandom_range(9);
		if (k == 0) return '0;
		if (k == 1) return GAIN_MAX;
		if (k == 2) return GAIN_ONE;
		return GAIN_W'({$urandom, $urandom} >> $urandom_range(16, 60));
	endfunction

	function automatic logic signed [16:0] pick_sample(int base);
		int k;
		k = $urandom_range(9);
		if (k < 2) return null_reg;
		if (k < 4) return 17'($urandom);
		return 17'(base + $urandom_range(0, 40) - 20);
	endfunction

	// One random tile with fresh settings on some registers.
	task automatic random_tile(int max_w, int max_h);
		normal_t none;
		int base, k;
		none = '{default: '0};
		drain();
		if ($urandom_range(3) != 0)
			write_reg(REG_TILE_WIDTH, CFG_DATA_W'($urandom_range(0, max_w)));
		if ($urandom_range(3) != 0)
			write_reg(REG_TILE_HEIGHT, CFG_DATA_W'($urandom_range(0, max_h)));
		if ($urandom_range(2) == 0) begin
			k = $urandom_range(5);
			write_reg(REG_NULL_VALUE, k == 0 ? 48'h10000 : (k == 1 ? 48'h0FFFF :
				CFG_DATA_W'(17'($urandom))));
		end
		if ($urandom_range(1) == 0) write_reg(REG_X_GAIN, pick_gain());
		if ($urandom_range(1) == 0) write_reg(REG_Y_GAIN, pick_gain());
		base = $urandom_range(0, 131071) - 65536;
		repeat ((eff_width() + 2) * (eff_height() + 2))
			push_height(pick_sample(base), 1'b0, none);
	endtask

	// Result checker: oldest expectation against each accepted word.
	always @(posedge clk) begin
		normal_t exp_n;
		if (arst_n && out_valid && out_ready) begin
			if (pending_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: x=%0d y=%0d z=%0d last=%0b",
						normal_x, normal_y, normal_z, last_of_tile);
			end else begin
				exp_n = pending_normals.pop_front();
				if (normal_x !== exp_n.nx || normal_y !== exp_n.ny ||
					normal_z !== exp_n.nz || last_of_tile !== exp_n.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%0d y=%0d z=%0d last=%0b, got x=%0d y=%0d z=%0d last=%0b",
							exp_n.nx, exp_n.ny, exp_n.nz, exp_n.last,
							normal_x, normal_y, normal_z, last_of_tile);
				end
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_asks != hold_done) begin
			hold_done = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_pct);
	end

	// Watchdog: cycles with no handshake on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	tile_row_t rows [4];

	initial begin
		normal_t none;
		none = '{default: '0};
		width_reg = 10'd64;
		height_reg = 13'd64;
		null_reg = '0;
		xgain_reg = GAIN_ONE;
		ygain_reg = GAIN_ONE;
		foreach (win[i]) win[i] = '0;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		col_pos = 0;
		row_pos = 0;

		// Flat tile: no slope, straight-up normal.
		rows[0] = '{w: 10'd1, h: 13'd1, nul: 17'sd0, xg: GAIN_ONE, yg: GAIN_ONE,
			px: '{5, 5, 5, 5, 5, 5, 5, 5, 5}, chk: 1'b1,
			want: '{nx: 16'sd0, ny: 16'sd0, nz: 16'd32768, last: 1'b1}};
		// Steepest rise in x at max gain: x saturates, z vanishes.
		rows[1] = '{w: 10'd1, h: 13'd1, nul: 17'sd7, xg: GAIN_MAX, yg: GAIN_MAX,
			px: '{0, 0, 0, -65536, 0, 65535, 0, 0, 0}, chk: 1'b1,
			want: '{nx: 16'sd32767, ny: 16'sd0, nz: 16'd0, last: 1'b1}};
		// Steepest fall in y, zero-sized tile registers (saturate to one).
		rows[2] = '{w: 10'd0, h: 13'd0, nul: 17'sd7, xg: GAIN_MAX, yg: GAIN_MAX,
			px: '{0, 65535, 0, 3, 0, 3, 0, -65536, 0}, chk: 1'b1,
			want: '{nx: 16'sd0, ny: -16'sd32767, nz: 16'd0, last: 1'b1}};
		// One-sided differences against null neighbors.
		rows[3] = '{w: 10'd1, h: 13'd1, nul: -17'sd9, xg: GAIN_ONE, yg: 48'd3 << 23,
			px: '{0, 5, 0, -9, 10, 1000, 0, -9, 0}, chk: 1'b0, want: none};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Phase A: sender idles often, receiver idles more.
		send_pct = 38;
		recv_pct = 77;
		foreach (rows[i]) begin
			drain();
			write_reg(REG_TILE_WIDTH, CFG_DATA_W'(rows[i].w));
			write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(rows[i].h));
			write_reg(REG_NULL_VALUE, CFG_DATA_W'(17'(rows[i].nul)));
			write_reg(REG_X_GAIN, rows[i].xg);
			write_reg(REG_Y_GAIN, rows[i].yg);
			for (int p = 0; p < 9; p++)
				push_height(rows[i].px[p], rows[i].chk, rows[i].want);
		end

		// Random tiles; the long receiver hold lands early in phase A.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
				send_pct = 0;
				recv_pct = 0;
			end else if (items_sent >= RANDOM_ITEMS / 3) begin
				send_pct = 77;
				recv_pct = 38;
			end
			if (hold_asks == 0 && items_sent > 60)
				hold_asks = 1;
			random_tile(6, 4);
		end

		// Let the pipeline empty, then give stragglers time to show up.
		drain();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && pending_normals.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
